FILE: hdl/tlpc_pkg.sv
// Shared types, phase codes, lamp codes and the digit segment table.
package tlpc_pkg;

    localparam int unsigned CFG_WIDTH = 16;
    localparam int unsigned CFG_INDEX_WIDTH = 2;

    typedef enum logic [CFG_INDEX_WIDTH-1:0] {
        CFG_GREEN_TICKS  = 2'd0,
        CFG_YELLOW_TICKS = 2'd1,
        CFG_DIGIT_TICKS  = 2'd2,
        CFG_FLASH_TICKS  = 2'd3
    } t_cfg_index;

    typedef enum logic [2:0] {
        PH_EWG   = 3'd0,
        PH_EWY   = 3'd1,
        PH_PED   = 3'd2,
        PH_NSG   = 3'd3,
        PH_NSY   = 3'd4,
        PH_REL1  = 3'd5,
        PH_FLASH = 3'd6,
        PH_REL2  = 3'd7
    } t_phase;

    localparam logic [2:0] LAMP_OFF = 3'b000;
    localparam logic [2:0] LAMP_RED = 3'b001;
    localparam logic [2:0] LAMP_YEL = 3'b010;
    localparam logic [2:0] LAMP_GRN = 3'b100;

    localparam logic [3:0] DIGIT_TOP = 4'd9;

    typedef struct packed {
        logic ped_button_n;
        logic safety_button_n;
    } t_in_beat;

    typedef struct packed {
        logic [2:0] ns_lamps;
        logic [2:0] ew_lamps;
        logic [7:0] segment_pattern;
        logic       ped_indicator;
        logic [2:0] phase_code;
    } t_out_beat;

    function automatic logic [7:0] digit_segments(input logic [3:0] digit);
        logic [7:0] seg;
        unique case (digit)
            4'd0:    seg = 8'h5F;
            4'd1:    seg = 8'h06;
            4'd2:    seg = 8'h9B;
            4'd3:    seg = 8'h8F;
            4'd4:    seg = 8'hC6;
            4'd5:    seg = 8'hCD;
            4'd6:    seg = 8'hDD;
            4'd7:    seg = 8'h07;
            4'd8:    seg = 8'hDF;
            4'd9:    seg = 8'hCF;
            default: seg = 8'h00;
        endcase
        return seg;
    endfunction

endpackage

FILE: hdl/traffic_light_pedestrian_controller.sv
// Traffic light controller with pedestrian countdown and safety flashing.
//
//  channel   signals                                     width
//  tick in   i_in_valid / o_in_ready / i_in_beat         2
//  result    o_out_valid / i_out_ready / o_out_beat      18
//  config    i_cfg_we / i_cfg_index / i_cfg_data         1 / 2 / 16
//
// One tick per cycle while the result is not stalled: a beat waits in the input register, then the
// phase update and lamp decode write the result register in a single pass.
// The result becomes valid when the beat moves from the input register into the result register.
// Synchronous active-low reset: EW green, count zero, display blank, flash state lit.
// A stalled result holds both stages; the input stage still fills while empty.
module traffic_light_pedestrian_controller
    import tlpc_pkg::*;
#(
    parameter int unsigned COUNT_WIDTH = 16
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_ready,
    input  t_in_beat                   i_in_beat,
    output logic                       o_out_valid,
    input  logic                       i_out_ready,
    output t_out_beat                  o_out_beat,
    input  logic                       i_cfg_we,
    input  logic [CFG_INDEX_WIDTH-1:0] i_cfg_index,
    input  logic [CFG_WIDTH-1:0]       i_cfg_data
);

    localparam int unsigned LW = (COUNT_WIDTH > CFG_WIDTH) ? COUNT_WIDTH : CFG_WIDTH;
    localparam logic [LW-1:0] CNT_MAX = LW'({COUNT_WIDTH{1'b1}});

    logic [CFG_WIDTH-1:0]   r_green_ticks, r_yellow_ticks, r_digit_ticks, r_flash_ticks;
    logic                   r_in_valid;
    t_in_beat               r_in;
    logic                   r_out_valid;
    t_out_beat              r_out;
    t_phase                 r_phase, n_phase;
    logic [COUNT_WIDTH-1:0] r_tick, n_tick;
    logic [3:0]             r_digit, n_digit;
    logic                   r_disp, n_disp;
    logic                   r_ped, n_ped;
    logic                   r_flash, n_flash;
    t_out_beat              n_out;

    logic                   step;
    logic                   ped, safety;
    logic [CFG_WIDTH-1:0]   len;
    logic [LW-1:0]          target, cur, inc;
    logic                   done;
    logic [COUNT_WIDTH-1:0] adv_tick;

    assign step        = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready  = !r_in_valid || step;
    assign o_out_valid = r_out_valid;
    assign o_out_beat  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_green_ticks  <= CFG_WIDTH'(600);
            r_yellow_ticks <= CFG_WIDTH'(300);
            r_digit_ticks  <= CFG_WIDTH'(100);
            r_flash_ticks  <= CFG_WIDTH'(50);
        end else if (i_cfg_we) begin
            unique case (t_cfg_index'(i_cfg_index))
                CFG_GREEN_TICKS:  r_green_ticks  <= i_cfg_data;
                CFG_YELLOW_TICKS: r_yellow_ticks <= i_cfg_data;
                CFG_DIGIT_TICKS:  r_digit_ticks  <= i_cfg_data;
                CFG_FLASH_TICKS:  r_flash_ticks  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_phase     <= PH_EWG;
            r_tick      <= '0;
            r_digit     <= DIGIT_TOP;
            r_disp      <= 1'b0;
            r_ped       <= 1'b0;
            r_flash     <= 1'b1;
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (step) begin
                r_out_valid <= 1'b1;
                r_phase     <= n_phase;
                r_tick      <= n_tick;
                r_digit     <= n_digit;
                r_disp      <= n_disp;
                r_ped       <= n_ped;
                r_flash     <= n_flash;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in <= i_in_beat;
        end
        if (step) begin
            r_out <= n_out;
        end
    end

    // shared phase timer
    always_comb begin
        unique case (r_phase)
            PH_EWG, PH_NSG: len = r_green_ticks;
            PH_EWY, PH_NSY: len = r_yellow_ticks;
            PH_PED:         len = r_digit_ticks;
            default:        len = r_flash_ticks;
        endcase
        target = LW'(len);
        if (target == '0) begin
            target = LW'(1);
        end
        if (target > CNT_MAX) begin
            target = CNT_MAX;
        end
        cur      = LW'(r_tick);
        inc      = (cur < CNT_MAX) ? cur + LW'(1) : cur;
        done     = inc >= target;
        adv_tick = done ? '0 : inc[COUNT_WIDTH-1:0];
    end

    always_comb begin
        ped     = !r_in.ped_button_n;
        safety  = !r_in.safety_button_n;
        n_phase = r_phase;
        n_tick  = r_tick;
        n_digit = r_digit;
        n_disp  = r_disp;
        n_ped   = r_ped;
        n_flash = r_flash;

        unique case (r_phase)
            PH_EWG, PH_EWY, PH_PED, PH_NSG, PH_NSY: begin
                if (ped) begin
                    n_ped = 1'b1;
                end
                if (safety) begin
                    n_phase = PH_REL1;
                    n_tick  = '0;
                end else begin
                    n_tick = adv_tick;
                    if (done) begin
                        unique case (r_phase)
                            PH_EWG: n_phase = PH_EWY;
                            PH_EWY: begin
                                if (n_ped) begin
                                    n_phase = PH_PED;
                                    n_digit = DIGIT_TOP;
                                    n_disp  = 1'b1;
                                end else begin
                                    n_phase = PH_NSG;
                                end
                            end
                            PH_PED: begin
                                if (r_digit == '0 || r_digit > DIGIT_TOP) begin
                                    n_ped   = 1'b0;
                                    n_disp  = 1'b0;
                                    n_phase = PH_NSG;
                                end else begin
                                    n_digit = r_digit - 4'd1;
                                end
                            end
                            PH_NSG:  n_phase = PH_NSY;
                            default: n_phase = PH_EWG;
                        endcase
                    end
                end
            end
            PH_REL1: begin
                if (!safety) begin
                    n_phase = PH_FLASH;
                    n_tick  = '0;
                    n_flash = 1'b1;
                end
            end
            PH_FLASH: begin
                if (ped) begin
                    n_ped = 1'b1;
                end
                if (safety) begin
                    n_phase = PH_REL2;
                    n_tick  = '0;
                end else begin
                    n_tick = adv_tick;
                    if (done) begin
                        n_flash = !r_flash;
                    end
                end
            end
            default: begin
                if (!safety) begin
                    n_phase = PH_EWG;
                    n_tick  = '0;
                end
            end
        endcase

        n_out.ns_lamps = LAMP_RED;
        n_out.ew_lamps = LAMP_RED;
        unique case (n_phase)
            PH_EWG:         n_out.ew_lamps = LAMP_GRN;
            PH_EWY:         n_out.ew_lamps = LAMP_YEL;
            PH_PED, PH_NSG: n_out.ns_lamps = LAMP_GRN;
            PH_NSY:         n_out.ns_lamps = LAMP_YEL;
            PH_FLASH: begin
                if (!n_flash) begin
                    n_out.ns_lamps = LAMP_OFF;
                    n_out.ew_lamps = LAMP_OFF;
                end
            end
            default: ;
        endcase
        n_out.segment_pattern = (n_disp && n_digit <= DIGIT_TOP) ?
                                digit_segments(n_digit) : 8'h00;
        n_out.ped_indicator   = n_ped;
        n_out.phase_code      = n_phase;
    end

endmodule

FILE: test/traffic_light_pedestrian_controller_test.sv
// Self-checking testbench for the traffic light controller with pedestrian countdown.
`timescale 1ns / 100ps

module traffic_light_pedestrian_controller_test;
    import tlpc_pkg::*;

    class tick_scoreboard;
        localparam int unsigned COUNT_MAX = 65535;

        int unsigned green_len;
        int unsigned yellow_len;
        int unsigned digit_len;
        int unsigned flash_len;
        t_phase      phase;
        int unsigned count;
        logic [3:0]  digit;
        bit          display_on;
        bit          ped_latched;
        bit          flash_lit;
        t_out_beat   expected_q[$];
        int unsigned mismatches;

        function new();
            green_len = 600;
            yellow_len = 300;
            digit_len = 100;
            flash_len = 50;
            phase = PH_EWG;
            count = 0;
            digit = 4'd9;
            display_on = 1'b0;
            ped_latched = 1'b0;
            flash_lit = 1'b1;
            mismatches = 0;
        endfunction

        function void write_reg(t_cfg_index idx, logic [CFG_WIDTH-1:0] value);
            case (idx)
                CFG_GREEN_TICKS:  green_len = value;
                CFG_YELLOW_TICKS: yellow_len = value;
                CFG_DIGIT_TICKS:  digit_len = value;
                CFG_FLASH_TICKS:  flash_len = value;
                default: ;
            endcase
        endfunction

        function logic [7:0] segments(logic [3:0] d);
            case (d)
                4'd0: return 8'h5F;
                4'd1: return 8'h06;
                4'd2: return 8'h9B;
                4'd3: return 8'h8F;
                4'd4: return 8'hC6;
                4'd5: return 8'hCD;
                4'd6: return 8'hDD;
                4'd7: return 8'h07;
                4'd8: return 8'hDF;
                4'd9: return 8'hCF;
                default: return 8'h00;
            endcase
        endfunction

        function void enter(t_phase nxt);
            phase = nxt;
            count = 0;
        endfunction

        function bit advance(int unsigned len);
            int unsigned target;
            target = (len == 0) ? 1 : len;
            if (target > COUNT_MAX) target = COUNT_MAX;
            if (count < COUNT_MAX) count++;
            if (count >= target) begin
                count = 0;
                return 1'b1;
            end
            return 1'b0;
        endfunction

        function void note_tick(t_in_beat b);
            bit        ped;
            bit        safety;
            t_out_beat e;
            ped = !b.ped_button_n;
            safety = !b.safety_button_n;
            if (phase <= PH_NSY) begin
                if (ped) ped_latched = 1'b1;
                if (safety) begin
                    enter(PH_REL1);
                end else begin
                    case (phase)
                        PH_EWG: if (advance(green_len)) enter(PH_EWY);
                        PH_EWY: begin
                            if (advance(yellow_len)) begin
                                if (ped_latched) begin
                                    enter(PH_PED);
                                    digit = 4'd9;
                                    display_on = 1'b1;
                                end else begin
                                    enter(PH_NSG);
                                end
                            end
                        end
                        PH_PED: begin
                            if (advance(digit_len)) begin
                                if (digit == 4'd0 || digit > 4'd9) begin
                                    ped_latched = 1'b0;
                                    display_on = 1'b0;
                                    enter(PH_NSG);
                                end else begin
                                    digit = digit - 4'd1;
                                end
                            end
                        end
                        PH_NSG: if (advance(green_len)) enter(PH_NSY);
                        default: if (advance(yellow_len)) enter(PH_EWG);
                    endcase
                end
            end else if (phase == PH_REL1) begin
                if (!safety) begin
                    enter(PH_FLASH);
                    flash_lit = 1'b1;
                end
            end else if (phase == PH_FLASH) begin
                if (ped) ped_latched = 1'b1;
                if (safety) enter(PH_REL2);
                else if (advance(flash_len)) flash_lit = !flash_lit;
            end else begin
                if (!safety) enter(PH_EWG);
            end

            e.ns_lamps = LAMP_RED;
            e.ew_lamps = LAMP_RED;
            case (phase)
                PH_EWG: e.ew_lamps = LAMP_GRN;
                PH_EWY: e.ew_lamps = LAMP_YEL;
                PH_PED, PH_NSG: e.ns_lamps = LAMP_GRN;
                PH_NSY: e.ns_lamps = LAMP_YEL;
                PH_FLASH: begin
                    if (!flash_lit) begin
                        e.ns_lamps = LAMP_OFF;
                        e.ew_lamps = LAMP_OFF;
                    end
                end
                default: ;
            endcase
            e.segment_pattern = (display_on && digit <= 4'd9) ? segments(digit) : 8'h00;
            e.ped_indicator = ped_latched;
            e.phase_code = phase;
            expected_q.push_back(e);
        endfunction

        task report(string what, int unsigned got, int unsigned want);
            $display("MISMATCH at %0t: %s got 0x%0h expected 0x%0h", $realtime, what, got, want);
            mismatches++;
        endtask

        task check_result(t_out_beat got);
            t_out_beat want;
            if (expected_q.size() == 0) begin
                report("unexpected beat", got, 0);
                return;
            end
            want = expected_q.pop_front();
            if (got.ns_lamps !== want.ns_lamps)
                report("ns_lamps", got.ns_lamps, want.ns_lamps);
            if (got.ew_lamps !== want.ew_lamps)
                report("ew_lamps", got.ew_lamps, want.ew_lamps);
            if (got.segment_pattern !== want.segment_pattern)
                report("segment_pattern", got.segment_pattern, want.segment_pattern);
            if (got.ped_indicator !== want.ped_indicator)
                report("ped_indicator", got.ped_indicator, want.ped_indicator);
            if (got.phase_code !== want.phase_code)
                report("phase_code", got.phase_code, want.phase_code);
        endtask
    endclass

    localparam logic [1:0] DIRECTED_SEQ [25] = '{
        2'b01, 2'b11, 2'b10, 2'b10, 2'b01, 2'b11, 2'b00, 2'b11, 2'b11, 2'b11,
        2'b11, 2'b11, 2'b11, 2'b11, 2'b11, 2'b11, 2'b11, 2'b11, 2'b11, 2'b01,
        2'b11, 2'b10, 2'b11, 2'b10, 2'b11
    };
    localparam int PHASE_ITEMS = 170;

    logic                       clk = 1'b0;
    logic                       rst_n = 1'b0;
    logic                       in_valid = 1'b0;
    logic                       in_ready;
    t_in_beat                   in_beat = '1;
    logic                       out_valid;
    logic                       out_ready = 1'b0;
    t_out_beat                  out_beat;
    logic                       cfg_we = 1'b0;
    logic [CFG_INDEX_WIDTH-1:0] cfg_index = '0;
    logic [CFG_WIDTH-1:0]       cfg_data = '0;

    int unsigned    send_idle = 0;
    int unsigned    recv_stall = 0;
    logic           hold_off = 1'b0;
    bit             pressure_go = 1'b0;
    bit             saf_level = 1'b1;
    int unsigned    saf_left = 10;
    tick_scoreboard sb;

    traffic_light_pedestrian_controller dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_beat   (in_beat),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_beat  (out_beat),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk) begin
        if (hold_off) out_ready <= 1'b0;
        else out_ready <= ($urandom_range(99) >= recv_stall);
    end

    initial begin
        wait (pressure_go);
        hold_off <= 1'b1;
        repeat (150) @(posedge clk);
        hold_off <= 1'b0;
    end

    always @(posedge clk) begin
        if (rst_n) begin
            if (in_valid && in_ready) sb.note_tick(in_beat);
            if (out_valid && out_ready) sb.check_result(out_beat);
        end
    end

    task automatic send_tick(t_in_beat b);
        while ($urandom_range(99) < send_idle) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_beat <= b;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
    endtask

    task automatic cfg_write(t_cfg_index idx, logic [CFG_WIDTH-1:0] value);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
        sb.write_reg(idx, value);
    endtask

    task automatic set_lengths(int unsigned g, int unsigned y, int unsigned d, int unsigned f);
        cfg_write(CFG_GREEN_TICKS, CFG_WIDTH'(g));
        cfg_write(CFG_YELLOW_TICKS, CFG_WIDTH'(y));
        cfg_write(CFG_DIGIT_TICKS, CFG_WIDTH'(d));
        cfg_write(CFG_FLASH_TICKS, CFG_WIDTH'(f));
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.expected_q.size() != 0) @(posedge clk);
        repeat (6) @(posedge clk);
    endtask

    // safety button alternates long released runs with short pressed runs
    function automatic t_in_beat next_beat();
        t_in_beat b;
        if (saf_left == 0) begin
            saf_level = !saf_level;
            saf_left = saf_level ? $urandom_range(40, 1) : $urandom_range(5, 1);
        end
        saf_left--;
        b.safety_button_n = saf_level;
        b.ped_button_n = ($urandom_range(5) != 0);
        return b;
    endfunction

    initial begin
        sb = new();
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        set_lengths(1, 1, 1, 1);
        for (int i = 0; i < 25; i++) send_tick(t_in_beat'(DIRECTED_SEQ[i]));
        drain();

        for (int p = 0; p < 6; p++) begin
            case (p)
                0: begin
                    set_lengths($urandom_range(6), $urandom_range(6),
                                $urandom_range(6), $urandom_range(6));
                    send_idle = 0;
                    recv_stall = 0;
                end
                1: begin
                    set_lengths(0, 0, 0, 0);
                    send_idle = 79;
                    recv_stall = 0;
                end
                2: begin
                    set_lengths($urandom_range(12, 1), $urandom_range(12, 1),
                                $urandom_range(12, 1), $urandom_range(12, 1));
                    send_idle = 0;
                    recv_stall = 79;
                end
                3: begin
                    set_lengths(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
                    send_idle = 7;
                    recv_stall = 7;
                end
                4: begin
                    set_lengths($urandom_range(4, 1), $urandom_range(4, 1),
                                $urandom_range(4, 1), $urandom_range(4, 1));
                    send_idle = 0;
                    recv_stall = 0;
                    pressure_go = 1'b1;
                end
                default: begin
                    set_lengths($urandom_range(40, 1), $urandom_range(3),
                                $urandom_range(2, 1), $urandom_range(3, 1));
                    send_idle = 30;
                    recv_stall = 30;
                end
            endcase
            for (int i = 0; i < PHASE_ITEMS; i++) send_tick(next_beat());
            drain();
        end

        if (sb.expected_q.size() != 0) sb.report("missing beats", 0, sb.expected_q.size());
        if (sb.mismatches == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("Verification failed");
        $finish;
    end

endmodule

FILE: filelist.f
hdl/tlpc_pkg.sv
hdl/traffic_light_pedestrian_controller.sv
test/traffic_light_pedestrian_controller_test.sv
